>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the pixel binning RTL.
// Each macro expects signals named clk and rst in the using scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> src/pba_pkg.sv
// ----------------------------------------------------------------------------
// pba_pkg
// Widths, register codes, shared types and reciprocal tables for the
// pixel binning block.
// ----------------------------------------------------------------------------
`default_nettype none

package pba_pkg;

  localparam int ROW_W      = 13;
  localparam int PIX_W      = 16;
  localparam int OUT_IDX_W  = 10;
  localparam int BIN_W      = 4;
  localparam int BLK_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam int BIN_EFF_W  = 5;
  localparam int BIN_SQ_W   = 9;

  localparam int REC_LIN_W     = 17;
  localparam int REC_LIN_SHIFT = 16;
  localparam int REC_SQ_W      = 25;
  localparam int REC_SQ_SHIFT  = 24;

  localparam int QDEPTH  = 16;
  localparam int QPTR_W  = 4;
  localparam int QCNT_W  = 5;

  localparam logic [BLK_W-1:0] COL_LIMIT = 11'd1024;

  localparam logic [CFG_IDX_W-1:0] REG_BIN_FACTOR    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_ACROSS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_DOWN   = 2'd2;

  typedef struct packed {
    logic                 last_blk;
    logic [OUT_IDX_W-1:0] out_col;
    logic [OUT_IDX_W-1:0] out_row;
  } pba_side_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] out_col;
    logic [OUT_IDX_W-1:0] out_row;
    logic [PIX_W-1:0]     mean_value;
  } pba_result_t;

  // floor(2^16 / d)
  function automatic logic [REC_LIN_W-1:0] recip_lin(input logic [BIN_EFF_W-1:0] d);
    logic [REC_LIN_W-1:0] r;
    unique case (d)
      5'd2:    r = 17'd32768;
      5'd3:    r = 17'd21845;
      5'd4:    r = 17'd16384;
      5'd5:    r = 17'd13107;
      5'd6:    r = 17'd10922;
      5'd7:    r = 17'd9362;
      5'd8:    r = 17'd8192;
      5'd9:    r = 17'd7281;
      5'd10:   r = 17'd6553;
      5'd11:   r = 17'd5957;
      5'd12:   r = 17'd5461;
      5'd13:   r = 17'd5041;
      5'd14:   r = 17'd4681;
      5'd15:   r = 17'd4369;
      5'd16:   r = 17'd4096;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

  // floor(2^24 / d^2)
  function automatic logic [REC_SQ_W-1:0] recip_sq(input logic [BIN_EFF_W-1:0] d);
    logic [REC_SQ_W-1:0] r;
    unique case (d)
      5'd2:    r = 25'd4194304;
      5'd3:    r = 25'd1864135;
      5'd4:    r = 25'd1048576;
      5'd5:    r = 25'd671088;
      5'd6:    r = 25'd466033;
      5'd7:    r = 25'd342392;
      5'd8:    r = 25'd262144;
      5'd9:    r = 25'd207126;
      5'd10:   r = 25'd167772;
      5'd11:   r = 25'd138654;
      5'd12:   r = 25'd116508;
      5'd13:   r = 25'd99273;
      5'd14:   r = 25'd85598;
      5'd15:   r = 25'd74565;
      5'd16:   r = 25'd65536;
      default: r = 25'd16777216;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/pba_if.sv
// ----------------------------------------------------------------------------
// pba_if
// Valid/ready stream interfaces for raw pixels and binned results.
// ----------------------------------------------------------------------------
`default_nettype none

interface pba_in_if;
  import pba_pkg::*;

  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] raw_row;
  logic [ROW_W-1:0] raw_col;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output raw_row, output raw_col, output pixel, input ready);
  modport sink   (input valid, input raw_row, input raw_col, input pixel, output ready);
endinterface

interface pba_out_if;
  import pba_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OUT_IDX_W-1:0] out_col;
  logic [OUT_IDX_W-1:0] out_row;
  logic [PIX_W-1:0]     mean_value;

  modport source (output valid, output out_col, output out_row, output mean_value,
                  input ready);
  modport sink   (input valid, input out_col, input out_row, input mean_value,
                  output ready);
endinterface

`default_nettype wire

>>> src/pixel_bin_average.sv
// ----------------------------------------------------------------------------
// pixel_bin_average
// Box-average binning of a raw sensor stream into bin x bin block means.
//
// raw carries one pixel per request with its raw row and column; binned
// carries one block mean per request with mirrored output column and
// output row. Three write-only registers (bin_factor, blocks_across,
// blocks_down) are set through cfg_wr_en / cfg_index / cfg_data; the user
// must do so only while idle, as the block does not enforce it. Throughput
// is one pixel per cycle while raw.ready is high; the single-port-read sum
// memory is read once per pixel and written once per binned pixel, with
// the previous write forwarded. Pixels that close no block, or lie outside
// the binned area, leave no result. Up to sixteen requests may be in flight
// or queued; raw.ready drops only when all sixteen slots are taken, so a
// stalled receiver stops input once sixteen results wait. Reset clears the
// pipeline, the queue and the registers (bin 2, 1024 x 1024 blocks); block
// sums are not cleared and a block must start at its top-left pixel.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pixel_bin_average #(
  parameter int MAX_BLOCKS_DOWN = 1024,
  parameter int MAX_BIN         = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [pba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pba_pkg::CFG_DATA_W-1:0]  cfg_data,
  pba_in_if.sink                          raw,
  pba_out_if.source                       binned
);
  import pba_pkg::*;

  localparam int SUM_W  = PIX_W + 2 * $clog2(MAX_BIN);
  localparam int ADDR_W = (MAX_BLOCKS_DOWN > 1) ? $clog2(MAX_BLOCKS_DOWN) : 1;

  logic [BIN_W-1:0] bin_factor;
  logic [BLK_W-1:0] blocks_across;
  logic [BLK_W-1:0] blocks_down;

  logic [BIN_EFF_W-1:0] bin_eff_next;
  logic [BIN_EFF_W-1:0] bin_eff;
  logic [BIN_EFF_W-1:0] bin_m1;
  logic [BIN_SQ_W-1:0]  bin_sq;
  logic [REC_LIN_W-1:0] rec_lin;
  logic [REC_SQ_W-1:0]  rec_sq;
  logic [BLK_W-1:0]     across_sat;
  logic [ROW_W-1:0]     down_sat;
  logic [2*BIN_EFF_W-1:0] sq_full;

  logic             s0_valid, s1_valid, s2_valid;
  logic [ROW_W-1:0] s0_row, s0_col;
  logic [PIX_W-1:0] s0_pix, s1_pix, s2_pix;

  logic [ROW_W-1:0]     brow, bcol;
  logic [BIN_EFF_W-1:0] rsub, csub;
  logic                 in_region;
  logic                 blk_start;
  logic [ROW_W-1:0]     mirror;
  pba_side_t            s2_side;

  logic             acc_valid, acc_wr;
  logic [SUM_W-1:0] acc_sum;
  pba_side_t        acc_side;

  logic       m1_valid, m2_valid;
  logic       m1_wr, m2_wr;
  pba_side_t  m1_side, m2_side;
  logic [SUM_W-1:0]    mean_q;
  logic [BIN_SQ_W-1:0] mean_r;

  logic              accept, push, drop, pop;
  logic [QCNT_W-1:0] credit;
  pba_result_t       result;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_factor    <= 4'd2;
      blocks_across <= 11'd1024;
      blocks_down   <= 11'd1024;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_BIN_FACTOR:    bin_factor    <= cfg_data[BIN_W-1:0];
        REG_BLOCKS_ACROSS: blocks_across <= cfg_data[BLK_W-1:0];
        REG_BLOCKS_DOWN:   blocks_down   <= cfg_data[BLK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (bin_factor == '0) begin
      bin_eff_next = BIN_EFF_W'(1);
    end else if ({1'b0, bin_factor} > BIN_EFF_W'(MAX_BIN)) begin
      bin_eff_next = BIN_EFF_W'(MAX_BIN);
    end else begin
      bin_eff_next = {1'b0, bin_factor};
    end
  end

  assign sq_full = {{BIN_EFF_W{1'b0}}, bin_eff} * {{BIN_EFF_W{1'b0}}, bin_eff};

  always_ff @(posedge clk) begin
    bin_eff    <= bin_eff_next;
    bin_m1     <= bin_eff - BIN_EFF_W'(1);
    bin_sq     <= sq_full[BIN_SQ_W-1:0];
    rec_lin    <= recip_lin(bin_eff_next);
    rec_sq     <= recip_sq(bin_eff);
    across_sat <= (blocks_across > COL_LIMIT) ? COL_LIMIT : blocks_across;
    down_sat   <= ({2'b0, blocks_down} > ROW_W'(MAX_BLOCKS_DOWN)) ?
                  ROW_W'(MAX_BLOCKS_DOWN) : {2'b0, blocks_down};
  end

  // input stage and side pipe alongside the coordinate dividers
  assign accept    = raw.valid && raw.ready;
  assign raw.ready = !rst && (credit < QCNT_W'(QDEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s0_valid <= accept;
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s0_row <= raw.raw_row;
    s0_col <= raw.raw_col;
    s0_pix <= raw.pixel;
    s1_pix <= s0_pix;
    s2_pix <= s1_pix;
  end

  pba_divq #(
    .NUM_W (ROW_W),
    .REC_W (REC_LIN_W),
    .SHIFT (REC_LIN_SHIFT),
    .DEN_W (BIN_EFF_W)
  ) u_div_row (
    .clk (clk),
    .num (s0_row),
    .rec (rec_lin),
    .den (bin_eff),
    .quo (brow),
    .rem (rsub)
  );

  pba_divq #(
    .NUM_W (ROW_W),
    .REC_W (REC_LIN_W),
    .SHIFT (REC_LIN_SHIFT),
    .DEN_W (BIN_EFF_W)
  ) u_div_col (
    .clk (clk),
    .num (s0_col),
    .rec (rec_lin),
    .den (bin_eff),
    .quo (bcol),
    .rem (csub)
  );

  always_comb begin
    in_region = (brow < {2'b0, across_sat}) && (bcol < down_sat);
    blk_start = (rsub == '0) && (csub == '0);
    mirror    = {2'b0, across_sat} - ROW_W'(1) - brow;
    s2_side.last_blk = (rsub == bin_m1) && (csub == bin_m1);
    s2_side.out_col  = mirror[OUT_IDX_W-1:0];
    s2_side.out_row  = bcol[OUT_IDX_W-1:0];
  end

  pba_accum #(
    .DEPTH  (MAX_BLOCKS_DOWN),
    .ADDR_W (ADDR_W),
    .SUM_W  (SUM_W)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_wr     (in_region),
    .in_start  (blk_start),
    .in_addr   (bcol[ADDR_W-1:0]),
    .in_pix    (s2_pix),
    .in_side   (s2_side),
    .out_valid (acc_valid),
    .out_wr    (acc_wr),
    .out_sum   (acc_sum),
    .out_side  (acc_side)
  );

  pba_divq #(
    .NUM_W (SUM_W),
    .REC_W (REC_SQ_W),
    .SHIFT (REC_SQ_SHIFT),
    .DEN_W (BIN_SQ_W)
  ) u_div_mean (
    .clk (clk),
    .num (acc_sum),
    .rec (rec_sq),
    .den (bin_sq),
    .quo (mean_q),
    .rem (mean_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
    end else begin
      m1_valid <= acc_valid;
      m2_valid <= m1_valid;
    end
  end

  always_ff @(posedge clk) begin
    m1_wr   <= acc_wr;
    m2_wr   <= m1_wr;
    m1_side <= acc_side;
    m2_side <= m1_side;
  end

  // hand a finished block to the queue, retire everything else here
  always_comb begin
    push              = m2_valid && m2_wr && m2_side.last_blk;
    drop              = m2_valid && !push;
    result.out_col    = m2_side.out_col;
    result.out_row    = m2_side.out_row;
    result.mean_value = mean_q[PIX_W-1:0];
  end

  pba_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (result),
    .pop       (pop),
    .binned    (binned)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else begin
      credit <= credit + QCNT_W'(accept) - QCNT_W'(drop) - QCNT_W'(pop);
    end
  end

  `ASSERT_IMPLIES(t_push_credited, push, credit != '0)
  `ASSERT_IMPLIES(t_out_credited, binned.valid, credit != '0)
  `ASSERT_IMPLIES(t_rem_range, m2_valid && m2_wr, mean_r < bin_sq)

endmodule

`default_nettype wire

>>> src/pba_divq.sv
// ----------------------------------------------------------------------------
// pba_divq
// Two-stage divider by a small runtime constant: reciprocal multiply,
// then one correction step.
// ----------------------------------------------------------------------------
`default_nettype none

module pba_divq #(
  parameter int NUM_W = 13,
  parameter int REC_W = 17,
  parameter int SHIFT = 16,
  parameter int DEN_W = 5
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [REC_W-1:0] rec,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rem
);

  logic [NUM_W+REC_W-1:0] prod;
  logic [NUM_W-1:0]       num_d;
  logic [DEN_W-1:0]       den_d;
  logic [NUM_W-1:0]       q_est;
  logic [NUM_W+DEN_W-1:0] qd;
  logic [NUM_W-1:0]       r_est;
  logic                   fix;

  always_ff @(posedge clk) begin
    prod  <= {{REC_W{1'b0}}, num} * {{NUM_W{1'b0}}, rec};
    num_d <= num;
    den_d <= den;
  end

  always_comb begin
    q_est = prod[SHIFT +: NUM_W];
    qd    = {{DEN_W{1'b0}}, q_est} * {{NUM_W{1'b0}}, den_d};
    r_est = num_d - qd[NUM_W-1:0];
    fix   = r_est >= NUM_W'(den_d);
  end

  always_ff @(posedge clk) begin
    if (fix) begin
      quo <= q_est + NUM_W'(1);
      rem <= DEN_W'(r_est - NUM_W'(den_d));
    end else begin
      quo <= q_est;
      rem <= DEN_W'(r_est);
    end
  end

endmodule

`default_nettype wire

>>> src/pba_accum.sv
// ----------------------------------------------------------------------------
// pba_accum
// Block sum memory: read, add the pixel or restart the sum, write back.
// Forwards the last write when the next request hits the same entry.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pba_accum #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int SUM_W  = 22
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_wr,
  input  logic                       in_start,
  input  logic [ADDR_W-1:0]          in_addr,
  input  logic [pba_pkg::PIX_W-1:0]  in_pix,
  input  pba_pkg::pba_side_t         in_side,
  output logic                       out_valid,
  output logic                       out_wr,
  output logic [SUM_W-1:0]           out_sum,
  output pba_pkg::pba_side_t         out_side
);
  import pba_pkg::*;

  logic [SUM_W-1:0] mem [DEPTH];
  logic [SUM_W-1:0] rd_data;

  logic              a_valid;
  logic              a_wr;
  logic              a_start;
  logic [ADDR_W-1:0] a_addr;
  logic [PIX_W-1:0]  a_pix;
  pba_side_t         a_side;
  logic [SUM_W-1:0]  a_base;
  logic [SUM_W-1:0]  a_sum;

  logic              f_valid;
  logic [ADDR_W-1:0] f_addr;
  logic [SUM_W-1:0]  f_data;

  always_ff @(posedge clk) begin
    rd_data <= mem[in_addr];
    if (a_valid && a_wr) begin
      mem[a_addr] <= a_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      f_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      a_valid   <= in_valid;
      f_valid   <= a_valid && a_wr;
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_wr     <= in_wr;
    a_start  <= in_start;
    a_addr   <= in_addr;
    a_pix    <= in_pix;
    a_side   <= in_side;
    f_addr   <= a_addr;
    f_data   <= a_sum;
    out_wr   <= a_wr;
    out_sum  <= a_sum;
    out_side <= a_side;
  end

  // take the write that lands in the same cycle as this read
  always_comb begin
    a_base = (f_valid && (f_addr == a_addr)) ? f_data : rd_data;
    a_sum  = a_start ? SUM_W'(a_pix) : a_base + SUM_W'(a_pix);
  end

  `ASSERT_IMPLIES(a_fwd_chain, $past(a_valid && a_wr) && a_valid && a_wr && !a_start && (a_addr == $past(a_addr)), a_sum == $past(a_sum) + SUM_W'(a_pix))
  `ASSERT_NEXT(a_out_follows, a_valid && a_wr, out_valid && out_wr)

endmodule

`default_nettype wire

>>> src/pba_outq.sv
// ----------------------------------------------------------------------------
// pba_outq
// Result queue between the binning pipeline and the output channel.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pba_outq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  pba_pkg::pba_result_t  push_data,
  output logic                  pop,
  pba_out_if.source             binned
);
  import pba_pkg::*;

  pba_result_t       q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign binned.valid      = count != '0;
  assign binned.out_col    = q_mem[rd_ptr].out_col;
  assign binned.out_row    = q_mem[rd_ptr].out_row;
  assign binned.mean_value = q_mem[rd_ptr].mean_value;
  assign pop               = binned.valid && binned.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  `ASSERT_IMPLIES(q_no_overflow, push, (count != QCNT_W'(QDEPTH)) || pop)
  `ASSERT_IMPLIES(q_count_range, 1'b1, count <= QCNT_W'(QDEPTH))

endmodule

`default_nettype wire
